// ----- sv/cau_pkg.sv -----
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

endpackage

// ----- sv/complex_arithmetic_unit.sv -----
// Path from request acceptance to result valid: three front stages,
// DATA_WIDTH + 1 divider cells and one output register.
// Throughput: one request per cycle; every stage holds its own valid bit and
// stalls only when the stage after it is full and stalled.
// Reset clears all valid bits; the data registers are not reset.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    localparam int S_TDATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_re, a_im, b_re, b_im, zero padding
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // res_re, res_im, zero padding
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [1:0]           m_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam int QB = W + 1;
    localparam int RW = 3 * W + 2;
    localparam int SW = 2 * MW + 7;
    localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

    logic          c_valid [0:QB];
    logic          c_ready [0:QB];
    logic [RW-1:0] c_rem_re [0:QB];
    logic [RW-1:0] c_rem_im [0:QB];
    logic [QB-1:0] c_q_re [0:QB];
    logic [QB-1:0] c_q_im [0:QB];
    logic [MW-1:0] c_den [0:QB];
    logic [SW-1:0] c_side [0:QB];

    logic                 out_ready;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    cau_pkg::op_t  f_op;
    logic          f_neg_re, f_neg_im, f_ovf_re, f_ovf_im, f_dz;
    logic [MW-1:0] f_mag_re_nd, f_mag_im_nd, f_mag_re, f_mag_im;
    logic [W-1:0]  res_re, res_im;
    logic          sat_re, sat_im;

    cau_front #(
        .W  (W),
        .F  (FRAC_BITS),
        .MW (MW),
        .QB (QB),
        .RW (RW),
        .SW (SW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .a_re       (s_tdata[W-1:0]),
        .a_im       (s_tdata[2*W-1:W]),
        .b_re       (s_tdata[3*W-1:2*W]),
        .b_im       (s_tdata[4*W-1:3*W]),
        .out_valid  (c_valid[0]),
        .out_ready  (c_ready[0]),
        .out_rem_re (c_rem_re[0]),
        .out_rem_im (c_rem_im[0]),
        .out_den    (c_den[0]),
        .out_side   (c_side[0])
    );

    assign c_q_re[0] = '0;
    assign c_q_im[0] = '0;

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        cau_div_cell #(
            .RW (RW),
            .DW (MW),
            .QB (QB),
            .K  (QB - 1 - i),
            .SW (SW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (c_valid[i]),
            .in_ready   (c_ready[i]),
            .in_rem_re  (c_rem_re[i]),
            .in_rem_im  (c_rem_im[i]),
            .in_q_re    (c_q_re[i]),
            .in_q_im    (c_q_im[i]),
            .in_den     (c_den[i]),
            .in_side    (c_side[i]),
            .out_valid  (c_valid[i+1]),
            .out_ready  (c_ready[i+1]),
            .out_rem_re (c_rem_re[i+1]),
            .out_rem_im (c_rem_im[i+1]),
            .out_q_re   (c_q_re[i+1]),
            .out_q_im   (c_q_im[i+1]),
            .out_den    (c_den[i+1]),
            .out_side   (c_side[i+1])
        );
    end

    assign out_ready   = !m_tvalid_reg || m_tready;
    assign c_ready[QB] = out_ready;

    always_comb
    begin
        f_op        = cau_pkg::op_t'(c_side[QB][1:0]);
        f_neg_re    = c_side[QB][2];
        f_neg_im    = c_side[QB][3];
        f_ovf_re    = c_side[QB][4];
        f_ovf_im    = c_side[QB][5];
        f_dz        = c_side[QB][6];
        f_mag_re_nd = c_side[QB][MW+6:7];
        f_mag_im_nd = c_side[QB][2*MW+6:MW+7];

        if (f_op == cau_pkg::OP_DIV)
        begin
            f_mag_re = f_ovf_re ? {{(MW-QB){1'b0}}, {QB{1'b1}}}
                                : {{(MW-QB){1'b0}}, c_q_re[QB]};
            f_mag_im = f_ovf_im ? {{(MW-QB){1'b0}}, {QB{1'b1}}}
                                : {{(MW-QB){1'b0}}, c_q_im[QB]};
        end
        else
        begin
            f_mag_re = f_mag_re_nd;
            f_mag_im = f_mag_im_nd;
        end

        sat_re = f_neg_re ? (f_mag_re > HALF) : (f_mag_re > HALF - MW'(1));
        sat_im = f_neg_im ? (f_mag_im > HALF) : (f_mag_im > HALF - MW'(1));

        if (sat_re)
            res_re = f_neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            res_re = f_neg_re ? W'(-f_mag_re) : f_mag_re[W-1:0];
        if (sat_im)
            res_im = f_neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            res_im = f_neg_im ? W'(-f_mag_im) : f_mag_im[W-1:0];

        if (f_dz)
        begin
            m_tdata_next = '0;
            m_tuser_next = cau_pkg::ST_DIV_ZERO;
        end
        else
        begin
            m_tdata_next = M_TDATA_W'({res_im, res_re});
            m_tuser_next = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_ready)
            m_tvalid_reg <= c_valid[QB];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && c_valid[QB])
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("Input stalled while the output was free.");

    a_div_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == cau_pkg::ST_DIV_ZERO) |-> (m_tdata == '0))
        else $error("Divide by zero gave a non-zero result.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == cau_pkg::ST_OK || m_tuser == cau_pkg::ST_DIV_ZERO
                      || m_tuser == cau_pkg::ST_SAT))
        else $error("Status code out of range.");

    a_output_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid[QB] && out_ready) |=> m_tvalid)
        else $error("A result from the last cell was lost.");

endmodule

// ----- sv/cau_front.sv -----
module cau_front #(
    parameter int W  = 16,
    parameter int F  = 8,
    parameter int MW = 2 * W + 1,
    parameter int QB = W + 1,
    parameter int RW = 3 * W + 2,
    parameter int SW = 2 * MW + 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [W-1:0]        a_re,
    input  logic [W-1:0]        a_im,
    input  logic [W-1:0]        b_re,
    input  logic [W-1:0]        b_im,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RW-1:0]       out_rem_re,
    output logic [RW-1:0]       out_rem_im,
    output logic [MW-1:0]       out_den,
    // side: op, neg_re, neg_im, ovf_re, ovf_im, div_zero, mag_re, mag_im (lowest first)
    output logic [SW-1:0]       out_side
);

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 rdy1, rdy2, rdy3;

    cau_pkg::op_t         op1_reg, op2_reg;
    logic signed [2*W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [2*W-1:0] p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [2*W-1:0] sq_r_next, sq_i_next;
    logic [2*W-1:0]       sq_r_reg, sq_i_reg;
    logic signed [W:0]    as_re_reg, as_im_reg, as_re_next, as_im_next;

    logic signed [MW-1:0] val_re_reg, val_im_reg, val_re_next, val_im_next;
    logic [MW-1:0]        den2_reg, den2_next;

    logic [MW-1:0]        mag_re, mag_im, mag_re_nd, mag_im_nd;
    logic                 neg_re, neg_im;
    logic [RW-1:0]        rem_re_next, rem_im_next, den_top;
    logic                 ovf_re, ovf_im, dz;
    logic [RW-1:0]        rem_re_reg, rem_im_reg;
    logic [MW-1:0]        den3_reg;
    logic [SW-1:0]        side_reg, side_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign p_rr_next = $signed(a_re) * $signed(b_re);
    assign p_ii_next = $signed(a_im) * $signed(b_im);
    assign p_ri_next = $signed(a_re) * $signed(b_im);
    assign p_ir_next = $signed(a_im) * $signed(b_re);
    assign sq_r_next = $signed(b_re) * $signed(b_re);
    assign sq_i_next = $signed(b_im) * $signed(b_im);

    always_comb
    begin
        if (cau_pkg::op_t'(op) == cau_pkg::OP_SUB)
        begin
            as_re_next = $signed({a_re[W-1], a_re}) - $signed({b_re[W-1], b_re});
            as_im_next = $signed({a_im[W-1], a_im}) - $signed({b_im[W-1], b_im});
        end
        else
        begin
            as_re_next = $signed({a_re[W-1], a_re}) + $signed({b_re[W-1], b_re});
            as_im_next = $signed({a_im[W-1], a_im}) + $signed({b_im[W-1], b_im});
        end
    end

    always_comb
    begin
        den2_next = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
        case (op1_reg)
            cau_pkg::OP_MUL:
            begin
                val_re_next = $signed({p_rr_reg[2*W-1], p_rr_reg})
                            - $signed({p_ii_reg[2*W-1], p_ii_reg});
                val_im_next = $signed({p_ri_reg[2*W-1], p_ri_reg})
                            + $signed({p_ir_reg[2*W-1], p_ir_reg});
            end
            cau_pkg::OP_DIV:
            begin
                val_re_next = $signed({p_rr_reg[2*W-1], p_rr_reg})
                            + $signed({p_ii_reg[2*W-1], p_ii_reg});
                val_im_next = $signed({p_ir_reg[2*W-1], p_ir_reg})
                            - $signed({p_ri_reg[2*W-1], p_ri_reg});
            end
            default:
            begin
                val_re_next = $signed({{(MW-W-1){as_re_reg[W]}}, as_re_reg});
                val_im_next = $signed({{(MW-W-1){as_im_reg[W]}}, as_im_reg});
            end
        endcase
    end

    always_comb
    begin
        neg_re      = val_re_reg[MW-1];
        neg_im      = val_im_reg[MW-1];
        mag_re      = neg_re ? MW'(-val_re_reg) : MW'(val_re_reg);
        mag_im      = neg_im ? MW'(-val_im_reg) : MW'(val_im_reg);
        mag_re_nd   = (op2_reg == cau_pkg::OP_MUL) ? (mag_re >> F) : mag_re;
        mag_im_nd   = (op2_reg == cau_pkg::OP_MUL) ? (mag_im >> F) : mag_im;
        rem_re_next = {{(RW-MW){1'b0}}, mag_re} << F;
        rem_im_next = {{(RW-MW){1'b0}}, mag_im} << F;
        den_top     = {{(RW-MW){1'b0}}, den2_reg} << QB;
        ovf_re      = rem_re_next >= den_top;
        ovf_im      = rem_im_next >= den_top;
        dz          = (op2_reg == cau_pkg::OP_DIV) && (den2_reg == '0);
        side_next   = {mag_im_nd, mag_re_nd, dz, ovf_im, ovf_re, neg_im, neg_re,
                       op2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            op1_reg   <= cau_pkg::op_t'(op);
            p_rr_reg  <= p_rr_next;
            p_ii_reg  <= p_ii_next;
            p_ri_reg  <= p_ri_next;
            p_ir_reg  <= p_ir_next;
            sq_r_reg  <= sq_r_next;
            sq_i_reg  <= sq_i_next;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
        if (rdy2 && v1_reg)
        begin
            op2_reg    <= op1_reg;
            val_re_reg <= val_re_next;
            val_im_reg <= val_im_next;
            den2_reg   <= den2_next;
        end
        if (rdy3 && v2_reg)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            den3_reg   <= den2_reg;
            side_reg   <= side_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_den    = den3_reg;
    assign out_side   = side_reg;

endmodule

// ----- sv/cau_div_cell.sv -----
module cau_div_cell #(
    parameter int RW = 50,
    parameter int DW = 33,
    parameter int QB = 17,
    parameter int K  = 0,
    parameter int SW = 73
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [RW-1:0] in_rem_re,
    input  logic [RW-1:0] in_rem_im,
    input  logic [QB-1:0] in_q_re,
    input  logic [QB-1:0] in_q_im,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [RW-1:0] out_rem_re,
    output logic [RW-1:0] out_rem_im,
    output logic [QB-1:0] out_q_re,
    output logic [QB-1:0] out_q_im,
    output logic [DW-1:0] out_den,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg, rem_re_next, rem_im_next, trial;
    logic [QB-1:0] q_re_reg, q_im_reg;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] side_reg;
    logic          ge_re, ge_im;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial       = {{(RW-DW){1'b0}}, in_den} << K;
        ge_re       = in_rem_re >= trial;
        ge_im       = in_rem_im >= trial;
        rem_re_next = ge_re ? in_rem_re - trial : in_rem_re;
        rem_im_next = ge_im ? in_rem_im - trial : in_rem_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= {in_q_re[QB-2:0], ge_re};
            q_im_reg   <= {in_q_im[QB-2:0], ge_im};
            den_reg    <= in_den;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;
    assign out_den    = den_reg;
    assign out_side   = side_reg;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int LATENCY = DW + 5;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] re;
        logic [15:0] im;
    } cplx_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    cplx_res_t   expected_q[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;

    complex_arithmetic_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Saturates a wide signed value to the result width and flags clipping.
    function automatic logic [15:0] clip(input logic signed [63:0] v, inout bit flag);
        if (v > 64'sd32767)
        begin
            flag = 1;
            return 16'h7fff;
        end
        if (v < -64'sd32768)
        begin
            flag = 1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Truncating division toward zero of num * 2^FB by den.
    function automatic logic signed [63:0] scaled_quot(input logic signed [63:0] num,
                                                       input logic signed [63:0] den);
        logic signed [63:0] mag;
        mag = ((num < 0 ? -num : num) <<< FB) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic cplx_res_t complex_result(input cau_pkg::op_t op,
                                                 input logic signed [15:0] ar,
                                                 input logic signed [15:0] ai,
                                                 input logic signed [15:0] br,
                                                 input logic signed [15:0] bi);
        cplx_res_t r;
        logic signed [63:0] xr, xi, den, pr, pi;
        bit flag;
        flag = 0;
        r.status = cau_pkg::ST_OK;
        case (op)
            cau_pkg::OP_ADD:
            begin
                xr = 64'(ar) + 64'(br);
                xi = 64'(ai) + 64'(bi);
            end
            cau_pkg::OP_SUB:
            begin
                xr = 64'(ar) - 64'(br);
                xi = 64'(ai) - 64'(bi);
            end
            cau_pkg::OP_MUL:
            begin
                pr = 64'(ar) * 64'(br) - 64'(ai) * 64'(bi);
                pi = 64'(ar) * 64'(bi) + 64'(ai) * 64'(br);
                xr = pr < 0 ? -((-pr) >>> FB) : pr >>> FB;
                xi = pi < 0 ? -((-pi) >>> FB) : pi >>> FB;
            end
            default:
            begin
                den = 64'(br) * 64'(br) + 64'(bi) * 64'(bi);
                if (den == 0)
                begin
                    r.re = '0;
                    r.im = '0;
                    r.status = cau_pkg::ST_DIV_ZERO;
                    return r;
                end
                xr = scaled_quot(64'(ar) * 64'(br) + 64'(ai) * 64'(bi), den);
                xi = scaled_quot(64'(ai) * 64'(br) - 64'(ar) * 64'(bi), den);
            end
        endcase
        r.re = clip(xr, flag);
        r.im = clip(xi, flag);
        if (flag)
            r.status = cau_pkg::ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(input cau_pkg::op_t op, input logic [15:0] ar,
                                input logic [15:0] ai, input logic [15:0] br,
                                input logic [15:0] bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {bi, br, ai, ar};
        expected_q.push_back(complex_result(op, ar, ai, br, bi));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1023)) - 512);
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        send_request(cau_pkg::OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'hff00, 16'h0100, 16'h0300, 16'hfd00);
        send_request(cau_pkg::OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
        send_request(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 4; k++)
                send_request(cau_pkg::op_t'(k), ext[i], ext[3 - i], ext[(i + k) % 4],
                             ext[k]);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(cau_pkg::op_t'($urandom_range(3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand());
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        hold_off = 1;
        test_random(150);
        drain();
        test_random(30);
        drain();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        mismatches = 0;
        hold_off = 0;
        send_idle_pct = 19;
        recv_idle_pct = 70;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        drain();
        send_idle_pct = 70;
        recv_idle_pct = 19;
        test_random(600);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550);
        drain();
        test_back_pressure();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cplx_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", m_tdata[15:0], 16'h0000);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.re)
                    report_mismatch("res_re", m_tdata[15:0], want.re);
                if (m_tdata[31:16] !== want.im)
                    report_mismatch("res_im", m_tdata[31:16], want.im);
                if (m_tuser !== want.status)
                    report_mismatch("status", 16'(m_tuser), 16'(want.status));
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
